/* sv/lbc_pkg.sv */
// ----------------------------------------------------------------------------
// lbc_pkg
// shared types, constants and round functions of the lblock 64/80 cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbc_pkg;

   localparam int unsigned ROUND_COUNT = 32;
   localparam int unsigned HALF_W      = 32;
   localparam int unsigned KEY_W       = 80;
   localparam int unsigned ROUND_W     = $clog2(ROUND_COUNT);
   localparam int unsigned CSR_IDX_W   = 2;

   // register map of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_UPPER    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOWER    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENCRYPT_MODE = 2'd2;

   // s-boxes 0..7 for the round function, 8 and 9 for the key schedule
   localparam logic [3:0] SBOX [10][16] = '{
      '{4'd14, 4'd9,  4'd15, 4'd0,  4'd13, 4'd4,  4'd10, 4'd11,
        4'd1,  4'd2,  4'd8,  4'd3,  4'd7,  4'd6,  4'd12, 4'd5},
      '{4'd4,  4'd11, 4'd14, 4'd9,  4'd15, 4'd13, 4'd0,  4'd10,
        4'd7,  4'd12, 4'd5,  4'd6,  4'd2,  4'd8,  4'd1,  4'd3},
      '{4'd1,  4'd14, 4'd7,  4'd12, 4'd15, 4'd13, 4'd0,  4'd6,
        4'd11, 4'd5,  4'd9,  4'd3,  4'd2,  4'd4,  4'd8,  4'd10},
      '{4'd7,  4'd6,  4'd8,  4'd11, 4'd0,  4'd15, 4'd3,  4'd14,
        4'd9,  4'd10, 4'd12, 4'd13, 4'd5,  4'd2,  4'd4,  4'd1},
      '{4'd14, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd12, 4'd13,
        4'd1,  4'd8,  4'd4,  4'd9,  4'd11, 4'd10, 4'd6,  4'd3},
      '{4'd2,  4'd13, 4'd11, 4'd12, 4'd15, 4'd14, 4'd0,  4'd9,
        4'd7,  4'd10, 4'd6,  4'd3,  4'd1,  4'd8,  4'd4,  4'd5},
      '{4'd11, 4'd9,  4'd4,  4'd14, 4'd0,  4'd15, 4'd10, 4'd13,
        4'd6,  4'd12, 4'd5,  4'd7,  4'd3,  4'd8,  4'd1,  4'd2},
      '{4'd13, 4'd10, 4'd15, 4'd0,  4'd14, 4'd4,  4'd9,  4'd11,
        4'd2,  4'd1,  4'd8,  4'd3,  4'd7,  4'd5,  4'd12, 4'd6},
      '{4'd8,  4'd7,  4'd14, 4'd5,  4'd15, 4'd13, 4'd0,  4'd6,
        4'd11, 4'd12, 4'd9,  4'd10, 4'd2,  4'd4,  4'd1,  4'd3},
      '{4'd11, 4'd5,  4'd15, 4'd0,  4'd7,  4'd2,  4'd9,  4'd13,
        4'd4,  4'd8,  4'd1,  4'd12, 4'd14, 4'd10, 4'd3,  4'd6}
   };

   // output nibble j takes s-box output nibble PERM_SRC[j]
   localparam logic [2:0] PERM_SRC [8] = '{3'd1, 3'd3, 3'd0, 3'd2, 3'd5, 3'd7, 3'd4, 3'd6};

   typedef struct packed {
      logic [HALF_W-1:0] left;
      logic [HALF_W-1:0] right;
      logic              skip;
   } stage_type;

   typedef logic [ROUND_COUNT-1:0][HALF_W-1:0] rk_array_type;

   // key xor, s-box layer, nibble permutation
   function automatic logic [HALF_W-1:0] round_fn(input logic [HALF_W-1:0] x,
                                                  input logic [HALF_W-1:0] k);
      logic [HALF_W-1:0] y;
      logic [HALF_W-1:0] s;
      logic [HALF_W-1:0] p;
      y = x ^ k;
      s = '0;
      p = '0;
      for (int j = 0; j < 8; j++) begin
         s[4*j +: 4] = SBOX[j][y[4*j +: 4]];
      end
      for (int j = 0; j < 8; j++) begin
         p[4*j +: 4] = s[4*PERM_SRC[j] +: 4];
      end
      return p;
   endfunction

   // one key schedule step: rotate left 29, s9/s8 on the top nibbles, round index mix
   function automatic logic [KEY_W-1:0] key_next(input logic [KEY_W-1:0] k,
                                                 input logic [ROUND_W-1:0] idx);
      logic [KEY_W-1:0] r;
      r = {k[50:0], k[79:51]};
      r[79:76] = SBOX[9][r[79:76]];
      r[75:72] = SBOX[8][r[75:72]];
      r[50:46] = r[50:46] ^ idx;
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/lbc_key_sched.sv */
// ----------------------------------------------------------------------------
// lbc_key_sched
// expands the 80-bit master key into the 32 round keys, one per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_key_sched
   import lbc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               restart,
   input  wire logic [15:0]        key_upper,
   input  wire logic [63:0]        key_lower,
   output      rk_array_type       round_keys,
   output      logic               keys_ready
);

   typedef enum logic [2:0] {
      KEY_LOAD = 3'b001,
      KEY_RUN  = 3'b010,
      KEY_DONE = 3'b100
   } key_state_type;

   key_state_type      state_ff, state_in;
   logic [KEY_W-1:0]   key_ff;
   logic [ROUND_W-1:0] cnt_ff;
   rk_array_type       rk_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         KEY_LOAD: state_in = KEY_RUN;
         KEY_RUN:  if (cnt_ff == ROUND_W'(ROUND_COUNT - 1)) state_in = KEY_DONE;
         KEY_DONE: state_in = KEY_DONE;
         default:  state_in = KEY_LOAD;
      endcase
      // a fresh key write starts the expansion over
      if (restart) state_in = KEY_LOAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= KEY_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == KEY_LOAD) begin
         key_ff <= {key_upper, key_lower};
         cnt_ff <= '0;
      end else if (state_ff == KEY_RUN) begin
         rk_ff[cnt_ff] <= key_ff[KEY_W-1 -: HALF_W];
         key_ff        <= key_next(key_ff, cnt_ff + ROUND_W'(1));
         cnt_ff        <= cnt_ff + ROUND_W'(1);
      end
   end

   assign round_keys = rk_ff;
   assign keys_ready = (state_ff == KEY_DONE) && !restart;

endmodule

`default_nettype wire

/* sv/lbc_round.sv */
// ----------------------------------------------------------------------------
// lbc_round
// one feistel round with its stage register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbc_round
   import lbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire logic              in_valid,
   input  wire stage_type         in_data,
   input  wire logic [HALF_W-1:0] round_key,
   input  wire logic              encrypt,
   output      logic              out_valid,
   output      stage_type         out_data
);

   logic              valid_ff;
   stage_type         data_ff, data_in;
   logic [HALF_W-1:0] f;
   logic [HALF_W-1:0] mix;
   logic [HALF_W-1:0] new_half;

   always_comb begin
      f = round_fn(in_data.left, round_key);
      if (encrypt) begin
         // rotate left 8 before the xor
         mix      = {in_data.right[23:0], in_data.right[31:24]} ^ f;
         new_half = mix;
      end else begin
         // rotate right 8 after the xor
         mix      = in_data.right ^ f;
         new_half = {mix[7:0], mix[31:8]};
      end
      data_in.left  = new_half;
      data_in.right = in_data.left;
      data_in.skip  = in_data.skip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

/* sv/lblock_block_cipher.sv */
// ----------------------------------------------------------------------------
// lblock_block_cipher
// lblock 64/80 block cipher, fully unrolled round pipeline
// ----------------------------------------------------------------------------
//
//  channel  ports                              direction  moves
//  req      req_valid req_ready req_block_in   in         one 64-bit block
//  rsp      rsp_valid rsp_ready rsp_block_out  out        one processed block
//           rsp_skipped                                   and its skip flag
//  csr      csr_valid csr_ready csr_index      in         one register write
//           csr_wdata
//
//  one item per cycle sustained while rsp_ready is high and keys are ready; each
//  item passes 32 round stages and then the output register of the unrolled pipeline
//  after reset and after every csr write the round keys are expanded, one
//  per cycle: req_ready stays low through one load and 32 key steps
//  reset is synchronous and active high; it clears valid bits, the key registers,
//  the key fsm and sets encrypt mode; a stall holds items in place; empty stages
//  still fill, so new items are taken behind a waiting result until all are full
//
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lblock_block_cipher
   import lbc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item input
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic [63:0]          req_block_in,
   // item output
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      logic [63:0]          rsp_block_out,
   output      logic                 rsp_skipped,
   // configuration writes
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   // configuration registers
   logic [15:0] key_upper_ff;
   logic [63:0] key_lower_ff;
   logic        encrypt_mode_ff;
   logic        csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff    <= '0;
         key_lower_ff    <= '0;
         encrypt_mode_ff <= 1'b1;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_KEY_UPPER:    key_upper_ff    <= csr_wdata[15:0];
            CSR_KEY_LOWER:    key_lower_ff    <= csr_wdata;
            CSR_ENCRYPT_MODE: encrypt_mode_ff <= csr_wdata[0];
            default:          ; // unknown index, write dropped
         endcase
      end
   end

   // round key expansion
   rk_array_type round_keys;
   logic         keys_ready;

   lbc_key_sched u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_fire),
      .key_upper  (key_upper_ff),
      .key_lower  (key_lower_ff),
      .round_keys (round_keys),
      .keys_ready (keys_ready)
   );

   // round pipeline: index 0 is the input side, index g+1 the output of round g
   logic      stage_valid [0:ROUND_COUNT];
   stage_type stage_data  [0:ROUND_COUNT];
   logic      stage_ready [1:ROUND_COUNT+1];

   assign req_ready      = stage_ready[1] && keys_ready;
   assign stage_valid[0] = req_valid && req_ready;
   // a zero block bypasses the cipher and is flagged
   assign stage_data[0]  = '{left:  req_block_in[63:32],
                             right: req_block_in[31:0],
                             skip:  (req_block_in == 64'd0)};

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
      logic [HALF_W-1:0] key_sel;

      // decryption walks the round keys backwards
      assign key_sel = encrypt_mode_ff ? round_keys[g] : round_keys[ROUND_COUNT-1-g];

      // a stage moves when it is empty or the next one moves
      assign stage_ready[g+1] = !stage_valid[g+1] || stage_ready[g+2];

      lbc_round u_round (
         .clock     (clock),
         .reset     (reset),
         .load      (stage_ready[g+1]),
         .in_valid  (stage_valid[g]),
         .in_data   (stage_data[g]),
         .round_key (key_sel),
         .encrypt   (encrypt_mode_ff),
         .out_valid (stage_valid[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // output register
   logic        rsp_valid_ff;
   logic [63:0] block_out_ff;
   logic        skipped_ff;

   assign stage_ready[ROUND_COUNT+1] = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_ready[ROUND_COUNT+1]) begin
         rsp_valid_ff <= stage_valid[ROUND_COUNT];
      end
   end

   // the last round does not swap halves, so undo the stage swap here
   always_ff @(posedge clock) begin
      if (stage_ready[ROUND_COUNT+1]) begin
         block_out_ff <= stage_data[ROUND_COUNT].skip ? 64'd0 :
                         {stage_data[ROUND_COUNT].right, stage_data[ROUND_COUNT].left};
         skipped_ff   <= stage_data[ROUND_COUNT].skip;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = block_out_ff;
   assign rsp_skipped   = skipped_ff;

endmodule

`default_nettype wire
